FILE: src/m3i_pkg.sv
// Package for the 3x3 matrix inverse: widths, fraction sizes and the cofactor operand table.
package m3i_pkg;

  localparam int IN_WIDTH_DEF  = 16;
  localparam int OUT_WIDTH_DEF = 32;
  localparam int IN_FRAC       = 8;
  localparam int OUT_FRAC      = 16;
  localparam int NUM_SHIFT     = IN_FRAC + OUT_FRAC;
  localparam int N_ELEM        = 9;

  // Element indexes in row-major order
  localparam int EA = 0;
  localparam int EB = 1;
  localparam int EC = 2;
  localparam int ED = 3;
  localparam int EE = 4;
  localparam int EF = 5;
  localparam int EG = 6;
  localparam int EH = 7;
  localparam int EI = 8;

  // Cofactor k = x[POS_A[k]]*x[POS_B[k]] - x[NEG_A[k]]*x[NEG_B[k]]
  localparam int POS_A [N_ELEM] = '{EE, EC, EB, EF, EA, EC, ED, EB, EA};
  localparam int POS_B [N_ELEM] = '{EI, EH, EF, EG, EI, ED, EH, EG, EE};
  localparam int NEG_A [N_ELEM] = '{EF, EB, EC, ED, EC, EA, EE, EA, EB};
  localparam int NEG_B [N_ELEM] = '{EH, EI, EE, EI, EG, EF, EG, EH, ED};

  // Per-lane status handed from the dividers to the merge stage
  typedef struct packed {
    logic ovf;
    logic neg;
  } lane_flags_t;

endpackage

FILE: src/m3i_intf.sv
// Handshake interfaces for the matrix input channel and the inverse output channel.
interface m3i_in_if #(
  parameter int IN_WIDTH = m3i_pkg::IN_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [IN_WIDTH-1:0] in_a, in_b, in_c, in_d, in_e, in_f, in_g, in_h, in_i;

  modport source (output valid, in_a, in_b, in_c, in_d, in_e, in_f, in_g, in_h, in_i,
                  input ready);
  modport sink   (input valid, in_a, in_b, in_c, in_d, in_e, in_f, in_g, in_h, in_i,
                  output ready);
endinterface

interface m3i_out_if #(
  parameter int OUT_WIDTH = m3i_pkg::OUT_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h, out_i;
  logic                        singular;
  logic                        clipped;

  modport source (output valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
                  out_i, singular, clipped, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, out_e, out_f, out_g, out_h,
                  out_i, singular, clipped, output ready);
endinterface

FILE: src/m3i_cofactor.sv
// Cofactor and determinant pipeline: five stages from matrix elements to |det| and cofactors.
module m3i_cofactor #(
  parameter int IN_WIDTH = m3i_pkg::IN_WIDTH_DEF,
  localparam int CW = 2 * IN_WIDTH + 1,
  localparam int MW = 3 * IN_WIDTH + 2
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [IN_WIDTH-1:0] elem_i [m3i_pkg::N_ELEM],
  output logic signed [CW-1:0]       cof_o  [m3i_pkg::N_ELEM],
  output logic        [MW-1:0]       dmag_o,
  output logic                       dneg_o,
  output logic                       sing_o
);
  localparam int PW = 2 * IN_WIDTH;
  localparam int TW = 3 * IN_WIDTH + 1;
  localparam int DW = 3 * IN_WIDTH + 3;
  localparam int N  = m3i_pkg::N_ELEM;

  logic signed [PW-1:0]       pp_q [N];
  logic signed [PW-1:0]       pn_q [N];
  logic signed [IN_WIDTH-1:0] r1_q [3];
  logic signed [IN_WIDTH-1:0] r2_q [3];
  logic signed [CW-1:0]       c2_q [N];
  logic signed [CW-1:0]       c3_q [N];
  logic signed [CW-1:0]       c4_q [N];
  logic signed [CW-1:0]       c5_q [N];
  logic signed [TW-1:0]       tm_q [3];
  logic signed [DW-1:0]       det_q;
  logic signed [DW-1:0]       det_d;
  logic        [MW-1:0]       dmag_q;
  logic                       dneg_q;
  logic                       sing_q;

  // Determinant sum of the three first-row terms
  assign det_d = DW'(tm_q[0]) + DW'(tm_q[1]) + DW'(tm_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: the eighteen pair products
      for (int k = 0; k < N; k++) begin
        pp_q[k] <= PW'(elem_i[m3i_pkg::POS_A[k]]) * PW'(elem_i[m3i_pkg::POS_B[k]]);
        pn_q[k] <= PW'(elem_i[m3i_pkg::NEG_A[k]]) * PW'(elem_i[m3i_pkg::NEG_B[k]]);
      end
      r1_q[0] <= elem_i[m3i_pkg::EA];
      r1_q[1] <= elem_i[m3i_pkg::EB];
      r1_q[2] <= elem_i[m3i_pkg::EC];
      // stage 2: cofactors
      for (int k = 0; k < N; k++) begin
        c2_q[k] <= CW'(pp_q[k]) - CW'(pn_q[k]);
      end
      r2_q <= r1_q;
      // stage 3: first-row terms
      tm_q[0] <= TW'(r2_q[0]) * TW'(c2_q[0]);
      tm_q[1] <= TW'(r2_q[1]) * TW'(c2_q[3]);
      tm_q[2] <= TW'(r2_q[2]) * TW'(c2_q[6]);
      c3_q    <= c2_q;
      // stage 4: determinant
      det_q <= det_d;
      c4_q  <= c3_q;
      // stage 5: magnitude and sign of the determinant
      dneg_q <= det_q[DW-1];
      sing_q <= (det_q == '0);
      dmag_q <= det_q[DW-1] ? MW'(-det_q) : MW'(det_q);
      c5_q   <= c4_q;
    end
  end

  assign cof_o  = c5_q;
  assign dmag_o = dmag_q;
  assign dneg_o = dneg_q;
  assign sing_o = sing_q;

endmodule

FILE: src/m3i_div_lane.sv
// One divider lane: restoring division of |cofactor| << shift by |det|, one quotient bit a stage.
module m3i_div_lane #(
  parameter int IN_WIDTH  = m3i_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = m3i_pkg::OUT_WIDTH_DEF,
  localparam int CW = 2 * IN_WIDTH + 1,
  localparam int MW = 3 * IN_WIDTH + 2
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [CW-1:0]     cof_i,
  input  logic        [MW-1:0]     dmag_i,
  input  logic                     dneg_i,
  output logic        [OUT_WIDTH-1:0] quo_o,
  output m3i_pkg::lane_flags_t     flags_o
);
  localparam int NW = CW + m3i_pkg::NUM_SHIFT;
  localparam int RW = MW + OUT_WIDTH + 1;
  localparam int NS = OUT_WIDTH + 2;

  logic [RW-1:0]        rem_q [NS];
  logic [MW-1:0]        dm_q  [NS];
  logic [OUT_WIDTH:0]   quo_q [NS];
  logic                 neg_q [NS];
  logic [CW-1:0]        pm;
  logic [NW-1:0]        num;

  // Magnitude of the cofactor, scaled to the output fraction
  assign pm  = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign num = {pm, {m3i_pkg::NUM_SHIFT{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num);
      dm_q[0]  <= dmag_i;
      quo_q[0] <= '0;
      neg_q[0] <= cof_i[CW-1] ^ dneg_i;
    end
  end

  // Stage s settles quotient bit OUT_WIDTH+1-s; the top bit flags overflow
  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = NS - 1 - s;
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(dm_q[s-1]) << K;
    assign take = rem_q[s-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? rem_q[s-1] - dsh : rem_q[s-1];
        dm_q[s]  <= dm_q[s-1];
        quo_q[s] <= quo_q[s-1] | ((OUT_WIDTH + 1)'(take) << K);
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign quo_o       = quo_q[NS-1][OUT_WIDTH-1:0];
  assign flags_o.ovf = quo_q[NS-1][OUT_WIDTH];
  assign flags_o.neg = neg_q[NS-1];

endmodule

FILE: src/m3i_merge.sv
// Merge stage: saturates and signs each lane quotient, zeroes singular results, folds the clip flags, holds the result.
module m3i_merge #(
  parameter int OUT_WIDTH = m3i_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic                        sing_i,
  input  logic        [OUT_WIDTH-1:0] quo_i   [m3i_pkg::N_ELEM],
  input  m3i_pkg::lane_flags_t        flags_i [m3i_pkg::N_ELEM],
  output logic                        vld_o,
  output logic signed [OUT_WIDTH-1:0] res_o   [m3i_pkg::N_ELEM],
  output logic                        sing_o,
  output logic                        clip_o
);
  localparam int N = m3i_pkg::N_ELEM;

  logic signed [OUT_WIDTH-1:0] res_d [N];
  logic signed [OUT_WIDTH-1:0] res_q [N];
  logic        [N-1:0]         sat;
  logic                        vld_q;
  logic                        sing_q;
  logic                        clip_q;

  // Per-lane limit, saturation and sign
  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [OUT_WIDTH-1:0] lim;
      logic [OUT_WIDTH-1:0] mag;
      lim    = flags_i[k].neg ? {1'b1, {(OUT_WIDTH - 1){1'b0}}}
                              : {1'b0, {(OUT_WIDTH - 1){1'b1}}};
      sat[k] = flags_i[k].ovf || (quo_i[k] > lim);
      mag    = sat[k] ? lim : quo_i[k];
      if (sing_i) begin
        res_d[k] = '0;
      end else begin
        res_d[k] = flags_i[k].neg ? $signed(-mag) : $signed(mag);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      sing_q <= sing_i;
      clip_q <= !sing_i && (|sat);
    end
  end

  assign vld_o  = vld_q;
  assign res_o  = res_q;
  assign sing_o = sing_q;
  assign clip_o = clip_q;

endmodule

FILE: src/matrix3_inverse.sv
// Top level of the pipelined 3x3 matrix inverse (adjugate over determinant, fixed point).
//
//   channel  | dir | payload                                   | handshake
//   in_if    | in  | in_a..in_i, IN_WIDTH signed Q8.8          | valid/ready
//   out_if   | out | out_a..out_i OUT_WIDTH Q16.16, flags      | valid/ready
//
// One matrix per cycle is accepted unless the output stalls; it passes five cofactor
// and determinant stages, OUT_WIDTH + 2 divider stages per lane and one output register.
// Nine divider lanes run side by side, one per inverse element.
// Reset clears only the valid bits; the block holds no state between items.
// The whole pipeline advances whenever the output register is empty or being taken.
module matrix3_inverse #(
  parameter int IN_WIDTH  = m3i_pkg::IN_WIDTH_DEF,
  parameter int OUT_WIDTH = m3i_pkg::OUT_WIDTH_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  m3i_in_if.sink   in_if,
  m3i_out_if.source out_if
);
  localparam int CW  = 2 * IN_WIDTH + 1;
  localparam int MW  = 3 * IN_WIDTH + 2;
  localparam int N   = m3i_pkg::N_ELEM;
  localparam int LAT = 5 + OUT_WIDTH + 2;
  localparam int DL  = OUT_WIDTH + 2;

  logic                        en;
  logic signed [IN_WIDTH-1:0]  elem [N];
  logic signed [CW-1:0]        cof  [N];
  logic        [MW-1:0]        dmag;
  logic                        dneg;
  logic                        sing;
  logic        [OUT_WIDTH-1:0] quo  [N];
  m3i_pkg::lane_flags_t        flags [N];
  logic signed [OUT_WIDTH-1:0] res  [N];
  logic        [LAT-1:0]       vld_q;
  logic        [DL-1:0]        sing_q;
  logic                        out_vld;

  assign en          = !out_vld || out_if.ready;
  assign in_if.ready = en;

  assign elem = '{in_if.in_a, in_if.in_b, in_if.in_c, in_if.in_d, in_if.in_e,
                  in_if.in_f, in_if.in_g, in_if.in_h, in_if.in_i};

  // Valid tracking alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_if.valid};
    end
  end

  // Singular flag follows the divider lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[DL-2:0], sing};
    end
  end

  m3i_cofactor #(.IN_WIDTH(IN_WIDTH)) u_cof (
    .clk_i  (clk_i),
    .en_i   (en),
    .elem_i (elem),
    .cof_o  (cof),
    .dmag_o (dmag),
    .dneg_o (dneg),
    .sing_o (sing)
  );

  for (genvar k = 0; k < N; k++) begin : g_lane
    m3i_div_lane #(.IN_WIDTH(IN_WIDTH), .OUT_WIDTH(OUT_WIDTH)) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .cof_i   (cof[k]),
      .dmag_i  (dmag),
      .dneg_i  (dneg),
      .quo_o   (quo[k]),
      .flags_o (flags[k])
    );
  end

  m3i_merge #(.OUT_WIDTH(OUT_WIDTH)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (vld_q[LAT-1]),
    .sing_i  (sing_q[DL-1]),
    .quo_i   (quo),
    .flags_i (flags),
    .vld_o   (out_vld),
    .res_o   (res),
    .sing_o  (out_if.singular),
    .clip_o  (out_if.clipped)
  );

  assign out_if.valid = out_vld;
  assign out_if.out_a = res[m3i_pkg::EA];
  assign out_if.out_b = res[m3i_pkg::EB];
  assign out_if.out_c = res[m3i_pkg::EC];
  assign out_if.out_d = res[m3i_pkg::ED];
  assign out_if.out_e = res[m3i_pkg::EE];
  assign out_if.out_f = res[m3i_pkg::EF];
  assign out_if.out_g = res[m3i_pkg::EG];
  assign out_if.out_h = res[m3i_pkg::EH];
  assign out_if.out_i = res[m3i_pkg::EI];

endmodule

FILE: src/m3i_checker.sv
// Port-level checks for the matrix inverse, bound to the top level.
module m3i_checker #(
  parameter int OUT_WIDTH = m3i_pkg::OUT_WIDTH_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [OUT_WIDTH-1:0] out_a_i,
  input logic                 singular_i,
  input logic                 clipped_i
);
  // A waiting result holds its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // A stalled output stalls the input side
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input accepted while output stalled");

  // Singular results carry no clip and a zero first element
  a_sing_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && singular_i |-> !clipped_i && (out_a_i == '0))
    else $error("singular result with clip or nonzero element");

  // Output valid never rises out of a stall: input ready must have been high before the rise
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_ready_i))
    else $error("result appeared during a stall");
endmodule

bind matrix3_inverse m3i_checker #(.OUT_WIDTH(OUT_WIDTH)) u_m3i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_a_i     (out_if.out_a),
  .singular_i  (out_if.singular),
  .clipped_i   (out_if.clipped)
);

FILE: dv/matrix3_inverse_test.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse.
module matrix3_inverse_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = m3i_pkg::IN_WIDTH_DEF;
  localparam int OW = m3i_pkg::OUT_WIDTH_DEF;
  localparam int NSH = m3i_pkg::NUM_SHIFT;
  localparam int LATENCY = OW + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [IW-1:0] elem_t;
  typedef struct packed {
    elem_t a, b, c, d, e, f, g, h, i;
  } matrix_t;
  typedef struct packed {
    logic signed [OW-1:0] a, b, c, d, e, f, g, h, i;
    logic singular;
    logic clipped;
  } inverse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  m3i_in_if  #(.IN_WIDTH(IW))  in_if ();
  m3i_out_if #(.OUT_WIDTH(OW)) out_if ();

  matrix3_inverse #(.IN_WIDTH(IW), .OUT_WIDTH(OW)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_t  pending_q[$];
  inverse_t expected_q[$];
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  bit          hold_off = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          stim_done = 1'b0;

  // Exact inverse element: trunc(cof * 2^NSH / det), saturated to OW bits.
  function automatic inverse_t invert(matrix_t m);
    inverse_t r;
    logic signed [63:0] x[9];
    logic signed [63:0] cof[9];
    logic signed [127:0] det, num, q;
    logic signed [127:0] maxv, minv;
    logic signed [OW-1:0] o[9];
    bit clip;
    x[0] = m.a; x[1] = m.b; x[2] = m.c; x[3] = m.d; x[4] = m.e;
    x[5] = m.f; x[6] = m.g; x[7] = m.h; x[8] = m.i;
    cof[0] = x[4]*x[8] - x[5]*x[7]; cof[1] = x[2]*x[7] - x[1]*x[8];
    cof[2] = x[1]*x[5] - x[2]*x[4]; cof[3] = x[5]*x[6] - x[3]*x[8];
    cof[4] = x[0]*x[8] - x[2]*x[6]; cof[5] = x[2]*x[3] - x[0]*x[5];
    cof[6] = x[3]*x[7] - x[4]*x[6]; cof[7] = x[1]*x[6] - x[0]*x[7];
    cof[8] = x[0]*x[4] - x[1]*x[3];
    det = 128'(x[0])*128'(cof[0]) + 128'(x[1])*128'(cof[3]) + 128'(x[2])*128'(cof[6]);
    maxv = (128'sd1 <<< (OW-1)) - 1;
    minv = -(128'sd1 <<< (OW-1));
    clip = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (det == 0) begin
        o[k] = '0;
      end else begin
        num = 128'(cof[k]) <<< NSH;
        q = num / det;  // SV signed division truncates toward zero
        if (q > maxv) begin
          o[k] = maxv[OW-1:0]; clip = 1'b1;
        end else if (q < minv) begin
          o[k] = minv[OW-1:0]; clip = 1'b1;
        end else begin
          o[k] = q[OW-1:0];
        end
      end
    end
    r = '{o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8], det == 0, clip};
    return r;
  endfunction

  // Driver: offers items from the pending queue, idling at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      {in_if.in_a, in_if.in_b, in_if.in_c, in_if.in_d, in_if.in_e,
       in_if.in_f, in_if.in_g, in_if.in_h, in_if.in_i} <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(invert(pending_q.pop_front()));
      end
      if ((!in_if.valid || in_if.ready)) begin
        if (pending_q.size() > 0 && !(in_if.valid && in_if.ready && pending_q.size() == 0)
            && $urandom_range(99) >= src_idle_pct) begin
          in_if.valid <= 1'b1;
          {in_if.in_i, in_if.in_h, in_if.in_g, in_if.in_f, in_if.in_e,
           in_if.in_d, in_if.in_c, in_if.in_b, in_if.in_a} <= {
           pending_q[0].i, pending_q[0].h, pending_q[0].g, pending_q[0].f, pending_q[0].e,
           pending_q[0].d, pending_q[0].c, pending_q[0].b, pending_q[0].a};
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk_i) begin
    if (hold_off) hold_cnt <= hold_cnt + 1;
    else hold_cnt <= 0;
  end

  // Monitor: takes results and compares them with the oldest expected inverse.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      int unsigned n_err;
      n_err = 0;
      cycles <= cycles + 1;
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with no expected inverse");
          n_err++;
        end else begin
          inverse_t ex, ac;
          ex = expected_q.pop_front();
          ac = '{out_if.out_a, out_if.out_b, out_if.out_c, out_if.out_d, out_if.out_e,
                 out_if.out_f, out_if.out_g, out_if.out_h, out_if.out_i,
                 out_if.singular, out_if.clipped};
          if (ex.a !== ac.a) begin $error("out_a exp %0d got %0d", ex.a, ac.a); n_err++; end
          if (ex.b !== ac.b) begin $error("out_b exp %0d got %0d", ex.b, ac.b); n_err++; end
          if (ex.c !== ac.c) begin $error("out_c exp %0d got %0d", ex.c, ac.c); n_err++; end
          if (ex.d !== ac.d) begin $error("out_d exp %0d got %0d", ex.d, ac.d); n_err++; end
          if (ex.e !== ac.e) begin $error("out_e exp %0d got %0d", ex.e, ac.e); n_err++; end
          if (ex.f !== ac.f) begin $error("out_f exp %0d got %0d", ex.f, ac.f); n_err++; end
          if (ex.g !== ac.g) begin $error("out_g exp %0d got %0d", ex.g, ac.g); n_err++; end
          if (ex.h !== ac.h) begin $error("out_h exp %0d got %0d", ex.h, ac.h); n_err++; end
          if (ex.i !== ac.i) begin $error("out_i exp %0d got %0d", ex.i, ac.i); n_err++; end
          if (ex.singular !== ac.singular) begin
            $error("singular exp %0d got %0d", ex.singular, ac.singular); n_err++;
          end
          if (ex.clipped !== ac.clipped) begin
            $error("clipped exp %0d got %0d", ex.clipped, ac.clipped); n_err++;
          end
        end
      end
      errors <= errors + n_err;
      out_if.ready <= !hold_off && ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Random element with a bias toward extremes and small values.
  function automatic elem_t rand_elem();
    case ($urandom_range(7))
      0: return elem_t'(-32768);
      1: return elem_t'(32767);
      2: return elem_t'($urandom_range(16) - 8);
      3: return elem_t'(($urandom_range(8) - 4) * 256);
      default: return elem_t'($urandom);
    endcase
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m = '{rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
          rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    case ($urandom_range(9))
      0: begin m.g = m.a; m.h = m.b; m.i = m.c; end          // repeated row: singular
      1: begin m.d = 0; m.e = 0; m.f = 0; end                // zero row
      2: begin m.b = 0; m.c = 0; m.d = 0; m.f = 0; m.g = 0; m.h = 0; end  // diagonal
      default: ;
    endcase
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_if.valid || expected_q.size() > 0) @(posedge clk_i);
  endtask

  localparam elem_t ONE = elem_t'(256);
  localparam elem_t MX = elem_t'(32767);
  localparam elem_t MN = elem_t'(-32768);

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: identity, negative identity, extremes, singular, tiny and clipping cases.
    pending_q.push_back('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
    pending_q.push_back('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE});
    pending_q.push_back('{MX, 0, 0, 0, MX, 0, 0, 0, MX});
    pending_q.push_back('{MN, 0, 0, 0, MN, 0, 0, 0, MN});
    pending_q.push_back('{1, 0, 0, 0, 1, 0, 0, 0, 1});
    pending_q.push_back('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
    pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    pending_q.push_back('{MX, MX, MX, MX, MX, MX, MX, MX, MX});
    pending_q.push_back('{MN, MX, MN, MX, MN, MX, MN, MX, MN});
    pending_q.push_back('{MN, MN, MN, MN, MX, MN, MN, MN, MX});
    pending_q.push_back('{0, ONE, 0, ONE, 0, 0, 0, 0, ONE});
    pending_q.push_back('{2*ONE, ONE, 0, ONE, 2*ONE, ONE, 0, ONE, 2*ONE});
    pending_q.push_back('{MX, 1, 0, 1, 1, 0, 0, 0, 1});
    pending_q.push_back('{elem_t'(-1), elem_t'(-1), 0, 0, elem_t'(-1), 0, 0, 0, MN});
    wait_drained();
    // Phase 1: sender idles rarely, receiver often; includes a long hold-off.
    src_idle_pct = 14; dst_idle_pct = 65;
    repeat (700) pending_q.push_back(rand_matrix());
    repeat (50) @(posedge clk_i);
    hold_off = 1'b1;
    while (hold_cnt < 300) @(posedge clk_i);
    hold_off = 1'b0;
    wait_drained();
    // Phase 2: the other way round.
    src_idle_pct = 65; dst_idle_pct = 14;
    repeat (650) pending_q.push_back(rand_matrix());
    wait_drained();
    // Phase 3: no idling.
    src_idle_pct = 0; dst_idle_pct = 0;
    repeat (650) pending_q.push_back(rand_matrix());
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // End of run: verdict or timeout.
  always @(posedge clk_i) begin
    if (stim_done) begin
      if (errors == 0 && expected_q.size() == 0) begin
        $display("matrix3_inverse regression: pass");
      end else begin
        if (expected_q.size() != 0) $error("%0d expected inverses never arrived", expected_q.size());
        $display("matrix3_inverse regression: fail");
      end
      $finish;
    end else if (cycles > CYCLE_LIMIT) begin
      $display("matrix3_inverse regression: fail");
      $finish;
    end
  end

endmodule
